// ----- sv/s2tl_pkg.sv -----
// Shared types, constants and helpers for the strip-to-triangle-list unit.
// No dependencies; imported by every module of the block.
package s2tl_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = 16;

  localparam logic [IDX_W-1:0] RESTART_INDEX = 16'hFFFF;

  localparam longint unsigned COUNT_SAT_INT =
    (COUNT_WIDTH >= 16) ? 64'hFFFF : ((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = COUNT_SAT_INT[COUNT_WIDTH-1:0];

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_LEAD0 = 3'b001,
    PH_LEAD1 = 3'b010,
    PH_STRIP = 3'b100
  } phase_t;

  typedef struct packed {
    logic [IDX_W-1:0]       older;
    logic [IDX_W-1:0]       newer;
    phase_t                 phase;
    logic                   wind;
    logic [COUNT_WIDTH-1:0] count;
  } strip_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] v0;
    logic [IDX_W-1:0] v1;
    logic [IDX_W-1:0] v2;
    logic             is_tri;
    logic             eom;
    logic [15:0]      count;
  } result_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] level;
    logic               room2;
  } fifo_stat_t;

  localparam strip_state_t STATE_CLEAR = '{
    older: '0, newer: '0, phase: PH_LEAD0, wind: 1'b0, count: '0
  };

  // Widen, then keep the low 16 bits of the count for the result field.
  function automatic logic [15:0] count_to_field(input logic [COUNT_WIDTH-1:0] c);
    logic [47:0] wide;
    wide = 48'(c);
    return wide[15:0];
  endfunction

endpackage

// ----- sv/s2tl_step.sv -----
// One strip step: byte swap, leading-pair load, restart, triangle and end marker.
// Pure combinational; depends on s2tl_pkg.
module s2tl_step import s2tl_pkg::*; (
  input  strip_state_t     cur,
  input  logic [IDX_W-1:0] raw_index,
  input  logic             last,
  input  logic [15:0]      vertex_count,
  output strip_state_t     nxt,
  output result_t          res0,
  output result_t          res1,
  output logic [1:0]       res_vld
);

  logic [IDX_W-1:0]       c;
  logic                   tri_hit;
  logic                   wind_nxt;
  logic [COUNT_WIDTH-1:0] count_nxt;
  strip_state_t           mid;
  result_t                tri_res;
  result_t                eom_res;

  assign c = {raw_index[7:0], raw_index[15:8]};

  always_comb begin
    mid       = cur;
    tri_hit   = 1'b0;
    wind_nxt  = cur.wind;
    count_nxt = cur.count;
    unique case (cur.phase)
      PH_LEAD0: begin
        mid.older = c;
        mid.phase = PH_LEAD1;
      end
      PH_LEAD1: begin
        mid.newer = c;
        mid.phase = PH_STRIP;
      end
      default: begin
        if (c == RESTART_INDEX) begin
          mid.phase = PH_LEAD0;
          mid.wind  = 1'b0;
        end else begin
          wind_nxt = ~cur.wind;
          tri_hit  = (vertex_count != 16'd0) && (cur.older != cur.newer) &&
                     (cur.newer != c) && (c != cur.older);
          if (tri_hit && (cur.count < COUNT_SAT)) begin
            count_nxt = cur.count + COUNT_WIDTH'(1);
          end
          mid.wind  = wind_nxt;
          mid.count = count_nxt;
          mid.older = cur.newer;
          mid.newer = c;
        end
      end
    endcase
  end

  always_comb begin
    tri_res.v0     = cur.older;
    tri_res.v1     = wind_nxt ? cur.newer : c;
    tri_res.v2     = wind_nxt ? c : cur.newer;
    tri_res.is_tri = 1'b1;
    tri_res.eom    = 1'b0;
    tri_res.count  = 16'd0;

    eom_res.v0     = '0;
    eom_res.v1     = '0;
    eom_res.v2     = '0;
    eom_res.is_tri = 1'b0;
    eom_res.eom    = 1'b1;
    eom_res.count  = (vertex_count != 16'd0) ? count_to_field(count_nxt) : 16'd0;
  end

  // Triangle always goes first; end marker fills the next free slot.
  always_comb begin
    res0    = tri_hit ? tri_res : eom_res;
    res1    = eom_res;
    res_vld = {tri_hit && last, tri_hit || last};
    nxt     = last ? STATE_CLEAR : mid;
  end

endmodule

// ----- sv/s2tl_fifo.sv -----
// Small result queue: up to two pushes and one pop per cycle.
// Depends on s2tl_pkg for result_t and the depth constants.
module s2tl_fifo import s2tl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push,
  input  result_t    din0,
  input  result_t    din1,
  input  logic       pop,
  output result_t    dout,
  output logic       not_empty,
  output fifo_stat_t stat
);

  result_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] level_r, level_nxt;
  logic               do_pop;

  assign not_empty  = (level_r != '0);
  assign do_pop     = pop && not_empty;
  assign dout       = mem_r[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.room2 = (level_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push[0]) + FIFO_AW'(push[1]);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(do_pop);
    level_nxt  = level_r + FIFO_CW'(push[0]) + FIFO_CW'(push[1]) - FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push[0]) begin
      mem_r[wr_ptr_r] <= din0;
    end
    if (push[1]) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

// ----- sv/strip_to_triangle_list_unit.sv -----
// Top level of the strip-to-triangle-list unit.
// Depends on s2tl_pkg, s2tl_step and s2tl_fifo.
//
// Converts a stream of big-endian 16-bit triangle-strip indices into a
// triangle list with primitive restart (0xFFFF after byte swap). One index
// request is taken per clock while the queue has room: it lands in an
// input register, one short combinational step (s2tl_step) updates the
// strip state and forms up to two results, and those go into a four-entry
// result queue that drives the out_ channel. Sustained rate is one index
// per cycle while each index gives at most one result and the queue has
// room; an index that closes a triangle and ends the mesh gives two
// results, which the queue absorbs. The input register advances only
// while the queue has room for two results.
// Write cfg_wr_data to vertex_count (zero suppresses triangles) only while
// the block is idle.
module strip_to_triangle_list_unit import s2tl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_raw_index,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_first_vertex,
  output logic [15:0] out_second_vertex,
  output logic [15:0] out_third_vertex,
  output logic        out_is_triangle,
  output logic        out_end_of_mesh,
  output logic [15:0] out_triangle_count
);

  logic [15:0]      vertex_count_r;
  logic             stg_vld_r, stg_vld_nxt;
  logic [IDX_W-1:0] stg_idx_r;
  logic             stg_last_r;
  strip_state_t     state_r, state_nxt;
  result_t          res0, res1, head;
  logic [1:0]       res_vld;
  logic             fire;
  logic             in_take;
  fifo_stat_t       q_stat;

  // Config register: plain write, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= 16'd0;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // Process the staged index when the queue can hold both possible results.
  assign fire     = stg_vld_r && q_stat.room2;
  assign in_ready = !stg_vld_r || fire;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    stg_vld_nxt = in_take ? 1'b1 : (fire ? 1'b0 : stg_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Hold payload until a new request is taken.
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_idx_r  <= in_raw_index;
      stg_last_r <= in_last;
    end
  end

  s2tl_step u_step (
    .cur          (state_r),
    .raw_index    (stg_idx_r),
    .last         (stg_last_r),
    .vertex_count (vertex_count_r),
    .nxt          (state_nxt),
    .res0         (res0),
    .res1         (res1),
    .res_vld      (res_vld)
  );

  // Strip state advances only on a processed index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  s2tl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire ? res_vld : 2'b00),
    .din0      (res0),
    .din1      (res1),
    .pop       (out_ready),
    .dout      (head),
    .not_empty (out_valid),
    .stat      (q_stat)
  );

  assign out_first_vertex   = head.v0;
  assign out_second_vertex  = head.v1;
  assign out_third_vertex   = head.v2;
  assign out_is_triangle    = head.is_tri;
  assign out_end_of_mesh    = head.eom;
  assign out_triangle_count = head.count;

`ifndef SYNTHESIS
  // Queue never overfills.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A mesh-ending index returns the strip to its start state.
  a_mesh_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && stg_last_r) |=> (state_r.phase == PH_LEAD0 && state_r.count == '0
                              && state_r.wind == 1'b0))
    else $error("strip state not cleared after last index");

  // A result is either a triangle or an end marker, never both nor neither.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_triangle != out_end_of_mesh))
    else $error("malformed result at head of queue");

  // Stage drains when the queue has room.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && q_stat.room2 && !in_valid) |=> !stg_vld_r)
    else $error("staged index not processed");
`endif

endmodule

// ----- tb/tb_strip_to_triangle_list_unit.sv -----
// Testbench for strip_to_triangle_list_unit: directed and random index streams
// checked against a built-in strip-to-list predictor. Depends on s2tl_pkg.
`timescale 1ns / 1ps

module tb_strip_to_triangle_list_unit import s2tl_pkg::*;;

  localparam int SETTLE_CYCLES  = 8;     // settle time after all expected results are in
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request on either side
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_ITEMS   = 1520;
  localparam int PHASE_ITEMS    = 195;

  // Predicts the triangle list and end markers and holds them until they
  // show up on the out_ channel.
  class triangle_scoreboard;
    logic [15:0]            vertex_count;
    logic [IDX_W-1:0]       older;
    logic [IDX_W-1:0]       newer;
    phase_t                 phase;
    logic                   wind;
    logic [COUNT_WIDTH-1:0] emitted;
    result_t                expected_q[$];
    int                     errors;

    function new();
      vertex_count = '0;
      errors = 0;
      clear_strip();
    endfunction

    function void clear_strip();
      older   = '0;
      newer   = '0;
      phase   = PH_LEAD0;
      wind    = 1'b0;
      emitted = '0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Append one expectation behind the ones already waiting.
    function void expect_result(result_t r);
      expected_q = {expected_q, r};
    endfunction

    // Advance the strip state by one accepted index request.
    function void note_request(logic [15:0] raw, logic last_flag);
      logic [IDX_W-1:0] c;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      result_t r;
      c = {raw[7:0], raw[15:8]};
      case (phase)
        PH_LEAD0: begin
          older = c;
          phase = PH_LEAD1;
        end
        PH_LEAD1: begin
          newer = c;
          phase = PH_STRIP;
        end
        default: begin
          if (c == RESTART_INDEX) begin
            phase = PH_LEAD0;
            wind  = 1'b0;
          end else begin
            a = older;
            b = newer;
            wind = ~wind;
            if (vertex_count != 0 && a != b && b != c && c != a) begin
              r.v0     = a;
              r.v1     = wind ? b : c;
              r.v2     = wind ? c : b;
              r.is_tri = 1'b1;
              r.eom    = 1'b0;
              r.count  = '0;
              expect_result(r);
              if (emitted < COUNT_SAT) emitted = emitted + 1'b1;
            end
            older = b;
            newer = c;
          end
        end
      endcase
      if (last_flag) begin
        r        = '0;
        r.eom    = 1'b1;
        r.count  = (vertex_count != 0) ? 16'(emitted) : 16'd0;
        expect_result(r);
        clear_strip();
      end
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("first_vertex",   exp_r.v0,     got.v0);
      check_field("second_vertex",  exp_r.v1,     got.v1);
      check_field("third_vertex",   exp_r.v2,     got.v2);
      check_field("is_triangle",    16'(exp_r.is_tri), 16'(got.is_tri));
      check_field("end_of_mesh",    16'(exp_r.eom),    16'(got.eom));
      check_field("triangle_count", exp_r.count,  got.count);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_raw_index = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_first_vertex;
  logic [15:0] out_second_vertex;
  logic [15:0] out_third_vertex;
  logic        out_is_triangle;
  logic        out_end_of_mesh;
  logic [15:0] out_triangle_count;

  triangle_scoreboard sb;
  result_t            seen;
  int                 idle_cycles = 0;
  int                 sink_run = 0;
  int                 sink_stall = 0;

  strip_to_triangle_list_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_index      (in_raw_index),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_vertex  (out_first_vertex),
    .out_second_vertex (out_second_vertex),
    .out_third_vertex  (out_third_vertex),
    .out_is_triangle   (out_is_triangle),
    .out_end_of_mesh   (out_end_of_mesh),
    .out_triangle_count(out_triangle_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the edge. Results are checked before the
  // request of the same edge is noted; a request never yields a result at
  // the edge it is accepted on.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen.v0     = out_first_vertex;
        seen.v1     = out_second_vertex;
        seen.v2     = out_third_vertex;
        seen.is_tri = out_is_triangle;
        seen.eom    = out_end_of_mesh;
        seen.count  = out_triangle_count;
        sb.check_result(seen);
      end
      if (in_valid && in_ready)
        sb.note_request(in_raw_index, in_last);
    end
  end

  // Receiver back-pressure: runs of ready broken by stalls, mostly short.
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      out_ready <= 1'b0;
      sink_stall = sink_stall - 1;
    end else if (sink_run > 0) begin
      out_ready <= 1'b1;
      sink_run = sink_run - 1;
    end else begin
      out_ready <= 1'b1;
      sink_run   = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 8);
      sink_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                               : $urandom_range(1, 3);
    end
  end

  // Watchdog: end the run if neither channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] to_raw(logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(0, 2);
  endfunction

  // Offer one index request and hold it until accepted. With gap 0 keep
  // valid high so the next call follows back to back; otherwise drop valid
  // and idle for gap cycles.
  task automatic send_request(input logic [15:0] raw, input logic last_flag,
                              input int gap);
    in_valid     <= 1'b1;
    in_raw_index <= raw;
    in_last      <= last_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every expected result, then let the pipeline
  // settle so an index that gave no result has surely passed through.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write vertex_count; call only while the block is idle.
  task automatic write_vertex_count(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.vertex_count = value;
  endtask

  // One mesh of random shape. Mostly well-formed strips with restarts,
  // drawn from a small pool (plenty of degenerate triangles) or the whole
  // index range; one in ten is raw noise. Lengths are mostly short.
  task automatic send_random_mesh(output int sent);
    int          len;
    int          kind;
    bit          burst;
    logic [15:0] v;
    logic [15:0] raw;
    kind  = $urandom_range(0, 9);
    len   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) begin
        raw = 16'($urandom);
      end else begin
        if (i >= 2 && $urandom_range(0, 9) == 0)
          v = RESTART_INDEX;
        else if (kind <= 4)
          v = 16'($urandom_range(0, 7));
        else
          v = 16'($urandom_range(0, 16'hFFFE));
        raw = to_raw(v);
      end
      send_request(raw, i == len - 1, burst ? 0 : pick_gap());
    end
    sent = len;
  endtask

  initial begin
    int          total;
    int          phase_count;
    int          mesh_len;
    int          plan_idx;
    logic [15:0] cfg_value;

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero vertex count out of reset: a full strip gives only the end marker.
    send_request(to_raw(16'd1), 1'b0, 0);
    send_request(to_raw(16'd2), 1'b0, 0);
    send_request(to_raw(16'd3), 1'b0, 1);
    send_request(to_raw(16'd4), 1'b1, 1);
    drain_and_settle();
    write_vertex_count(16'hFFFF);

    // Short meshes: last on the first or second leading index; a leading
    // index of 0xFFFF is loaded, not taken as restart.
    send_request(to_raw(16'd0), 1'b1, 0);
    send_request(to_raw(16'hFFFF), 1'b0, 0);
    send_request(16'h1234, 1'b1, 2);

    // Strip with both windings, a restart followed by a 0xFFFF leading
    // index, degenerate triangles, and a triangle on the last index so two
    // results come from one request.
    send_request(to_raw(16'd1), 1'b0, 0);
    send_request(to_raw(16'd2), 1'b0, 0);
    send_request(to_raw(16'd3), 1'b0, 0);
    send_request(to_raw(16'd4), 1'b0, 0);
    send_request(to_raw(16'hFFFF), 1'b0, 0);
    send_request(to_raw(16'hFFFF), 1'b0, 0);
    send_request(to_raw(16'd5), 1'b0, 0);
    send_request(to_raw(16'd6), 1'b0, 0);
    send_request(to_raw(16'd6), 1'b0, 0);
    send_request(to_raw(16'd8), 1'b0, 0);
    send_request(to_raw(16'd9), 1'b1, 0);

    // Restart as the last index: no triangle, end marker as usual.
    send_request(to_raw(16'd1), 1'b0, 0);
    send_request(to_raw(16'd2), 1'b0, 0);
    send_request(to_raw(16'hFFFF), 1'b1, 1);

    // Register change in the middle of a mesh, with extreme index values.
    send_request(to_raw(16'd0), 1'b0, 0);
    send_request(to_raw(16'hFFFE), 1'b0, 0);
    send_request(to_raw(16'hFEFF), 1'b0, 1);
    drain_and_settle();
    write_vertex_count(16'd0);
    send_request(to_raw(16'd1), 1'b0, 1);
    drain_and_settle();
    write_vertex_count(16'd1);
    send_request(to_raw(16'h7F80), 1'b1, 1);
    drain_and_settle();

    // Random phases, each under its own vertex count; plan entries without
    // a fixed value take a random one. Every phase boundary pauses the
    // sender until all expected results are in.
    total    = 0;
    plan_idx = 0;
    while (total < RANDOM_ITEMS) begin
      case (plan_idx % 8)
        0:       cfg_value = 16'd1;
        1:       cfg_value = 16'hFFFF;
        2:       cfg_value = 16'd0;
        5:       cfg_value = 16'hFFFF;
        7:       cfg_value = 16'd2;
        default: cfg_value = 16'($urandom_range(1, 16'hFFFF));
      endcase
      write_vertex_count(cfg_value);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS && total + phase_count < RANDOM_ITEMS) begin
        send_random_mesh(mesh_len);
        phase_count += mesh_len;
        // Now and then pause mid-phase until the result queue runs dry.
        if ($urandom_range(0, 29) == 0) drain_and_settle();
      end
      total += phase_count;
      plan_idx++;
      drain_and_settle();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- strip_to_triangle_list_unit.f -----
sv/s2tl_pkg.sv
sv/s2tl_step.sv
sv/s2tl_fifo.sv
sv/strip_to_triangle_list_unit.sv
tb/tb_strip_to_triangle_list_unit.sv
